/* hw/rtl/u256alu_pkg.sv */
// Shared types and constants of the 256-bit arithmetic unit.
`default_nettype none
package u256alu_pkg;
    localparam int unsigned NUM_BYTES = 32;
    localparam int unsigned W = NUM_BYTES * 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_REM = 3'd4
    } t_op;

    typedef struct packed {
        t_op          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W:0]   acc;
        logic [W-1:0] q;
        logic         dbz;
        logic         lt;
        logic         eq;
    } t_stage;
endpackage
`default_nettype wire

/* hw/rtl/u256alu_cell.sv */
// One cell of the chain: one divide step and one multiply step per cell.
`default_nettype none
module u256alu_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  u256alu_pkg::t_stage  i_data,
    output logic                 o_valid,
    output u256alu_pkg::t_stage  o_data
);
    localparam int unsigned W = u256alu_pkg::W;

    logic                r_valid;
    u256alu_pkg::t_stage r_data;
    u256alu_pkg::t_stage n_data;
    logic [W:0]          w_shift;
    logic [W:0]          w_bext;

    always_comb begin
        n_data  = i_data;
        w_bext  = {1'b0, i_data.b};
        w_shift = {i_data.acc[W-1:0], i_data.a[W-1-IDX]};
        if (i_data.op == u256alu_pkg::OP_DIV || i_data.op == u256alu_pkg::OP_REM) begin
            if (w_shift >= w_bext) begin
                n_data.acc          = w_shift - w_bext;
                n_data.q[W-1-IDX]   = 1'b1;
            end else begin
                n_data.acc = w_shift;
            end
        end else if (i_data.op == u256alu_pkg::OP_MUL && i_data.a[IDX]) begin
            n_data.acc = {1'b0, i_data.acc[W-1:0] + (i_data.b << IDX)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

/* hw/rtl/uint256_arithmetic_unit.sv */
// Top level: 256-bit add, subtract, multiply, divide and remainder over a cell chain.
// Each accepted input word is registered through every cell of the chain to the result.
// Throughput: one word per cycle; the chain advances as a whole unless the output stalls.
// Each of the 256 cells does one restoring divide step and one shift-add multiply step.
// Reset (synchronous, active low) clears all valid flags; no results are pending after it.
`default_nettype none
module uint256_arithmetic_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [511:0] s_axis_tdata,  // a_word0..a_word3, b_word0..b_word3
    input  wire  [2:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [255:0] m_axis_tdata,  // res_word0..res_word3
    output logic [2:0]   m_axis_tuser   // div_by_zero, a_less_than_b, a_equals_b
);
    localparam int unsigned W = u256alu_pkg::W;

    logic                w_en;
    logic                w_valid [W+1];
    u256alu_pkg::t_stage w_data  [W+1];
    u256alu_pkg::t_stage w_head;
    logic [W-1:0]        w_a;
    logic [W-1:0]        w_b;
    logic                w_bz;
    u256alu_pkg::t_op    w_op;
    u256alu_pkg::t_stage w_last;

    assign w_en          = !w_valid[W] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_a           = s_axis_tdata[W-1:0];
    assign w_b           = s_axis_tdata[2*W-1:W];
    assign w_bz          = (w_b == '0);
    assign w_op          = u256alu_pkg::t_op'(s_axis_tuser);

    always_comb begin
        w_head     = '0;
        w_head.op  = w_op;
        w_head.a   = w_a;
        w_head.b   = w_b;
        w_head.lt  = (w_a < w_b);
        w_head.eq  = (w_a == w_b);
        w_head.dbz = w_bz && (w_op == u256alu_pkg::OP_DIV || w_op == u256alu_pkg::OP_REM);
        if (w_op == u256alu_pkg::OP_ADD) begin
            w_head.acc = {1'b0, w_a + w_b};
        end else if (w_op == u256alu_pkg::OP_SUB) begin
            w_head.acc = {1'b0, w_a - w_b};
        end
    end

    assign w_data[0]  = w_head;
    assign w_valid[0] = s_axis_tvalid;

    for (genvar g = 0; g < W; g++) begin : g_cell
        u256alu_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign w_last        = w_data[W];
    assign m_axis_tvalid = w_valid[W];
    assign m_axis_tuser  = {w_last.eq, w_last.lt, w_last.dbz};

    always_comb begin
        unique case (w_last.op)
            u256alu_pkg::OP_ADD,
            u256alu_pkg::OP_SUB,
            u256alu_pkg::OP_MUL: m_axis_tdata = w_last.acc[W-1:0];
            u256alu_pkg::OP_DIV: m_axis_tdata = w_last.dbz ? '0 : w_last.q;
            u256alu_pkg::OP_REM: m_axis_tdata = w_last.dbz ? '0 : w_last.acc[W-1:0];
            default:             m_axis_tdata = '0;
        endcase
    end

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))
        else $error("less-than and equal flags both set");

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("divide by zero with nonzero result");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while chain stalled");
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the 256-bit arithmetic unit: directed and random words against a predictor.
`timescale 1ns / 1ps
module tb;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [511:0] s_axis_tdata = '0;   // a_word0..a_word3, b_word0..b_word3
    logic [2:0]   s_axis_tuser = '0;   // action
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [255:0] m_axis_tdata;        // res_word0..res_word3
    logic [2:0]   m_axis_tuser;        // div_by_zero, a_less_than_b, a_equals_b

    typedef struct packed {
        logic [255:0] res;
        logic         dbz;
        logic         lt;
        logic         eq;
    } t_result;

    t_result      pending_results[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;
    localparam int WATCHDOG = 20000;

    uint256_arithmetic_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result predict_alu(logic [2:0] op, logic [255:0] a, logic [255:0] b);
        t_result      r;
        logic [256:0] part;
        logic [255:0] quo;
        r = '0;
        r.lt = a < b;
        r.eq = a == b;
        part = '0;
        quo = '0;
        if ((op == u256alu_pkg::OP_DIV || op == u256alu_pkg::OP_REM) && b != 0) begin
            for (int i = 255; i >= 0; i--) begin
                part = {part[255:0], a[i]};
                if (part >= {1'b0, b}) begin
                    part = part - {1'b0, b};
                    quo[i] = 1'b1;
                end
            end
        end
        case (op)
            u256alu_pkg::OP_ADD: r.res = a + b;
            u256alu_pkg::OP_SUB: r.res = a - b;
            u256alu_pkg::OP_MUL: r.res = a * b;
            u256alu_pkg::OP_DIV: begin
                r.dbz = b == 0;
                r.res = quo;
            end
            u256alu_pkg::OP_REM: begin
                r.dbz = b == 0;
                r.res = b == 0 ? '0 : a - quo * b;
            end
            default: r.res = '0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [255:0] got, logic [255:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [255:0] rand_wide();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    task automatic send_word(logic [2:0] op, logic [255:0] a, logic [255:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        pending_results.push_back(predict_alu(op, a, b));
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold m_axis_tready low in random bursts
    always @(negedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, '0);
            end else begin
                t_result want;
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.res) report_mismatch("result", m_axis_tdata, want.res);
                if (m_axis_tuser[0] !== want.dbz)
                    report_mismatch("div_by_zero", 256'(m_axis_tuser[0]), 256'(want.dbz));
                if (m_axis_tuser[1] !== want.lt)
                    report_mismatch("a_less_than_b", 256'(m_axis_tuser[1]), 256'(want.lt));
                if (m_axis_tuser[2] !== want.eq)
                    report_mismatch("a_equals_b", 256'(m_axis_tuser[2]), 256'(want.eq));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_extremes();
        logic [255:0] vals[6];
        vals = '{'0, 256'd1, '1, {1'b1, 255'd0}, {1'b1, 255'd1}, {128'd0, {128{1'b1}}}};
        for (int op = 0; op < 8; op++) begin
            send_word(op[2:0], vals[op % 6], vals[(op + 2) % 6]);
        end
        send_word(u256alu_pkg::OP_DIV, '1, '0);
        send_word(u256alu_pkg::OP_REM, 256'd5, '0);
        send_word(u256alu_pkg::OP_DIV, '1, {1'b1, 255'd1});
        send_word(u256alu_pkg::OP_REM, '1, {1'b1, 255'd1});
        send_word(u256alu_pkg::OP_DIV, 256'd7, '1);
        send_word(u256alu_pkg::OP_MUL, '1, '1);
        send_word(u256alu_pkg::OP_ADD, '1, 256'd1);
        send_word(u256alu_pkg::OP_SUB, '0, 256'd1);
        send_word(u256alu_pkg::OP_REM, '1, '1);
        send_word(u256alu_pkg::OP_DIV, {1'b1, 255'd0}, 256'd3);
    endtask

    task automatic test_random_ops(int count);
        logic [255:0] a, b;
        logic [2:0]   op;
        for (int i = 0; i < count; i++) begin
            a = rand_wide();
            b = rand_wide();
            case ($urandom_range(0, 5))
                0: b = b >> $urandom_range(0, 255);
                1: a = a >> $urandom_range(0, 255);
                2: b = a;
                3: b = b >> 192;
                4: if ($urandom_range(0, 3) == 0) b = '0;
                default: ;
            endcase
            op = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
            send_word(op, a, b);
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < WATCHDOG) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_random_ops(580);
        quiet = 1'b1;
        test_random_ops(100);
        finish_run();
    end
endmodule

/* files.f */
hw/rtl/u256alu_pkg.sv
hw/rtl/u256alu_cell.sv
hw/rtl/uint256_arithmetic_unit.sv
tb/tb.sv
